// ----- design/lrl_pkg.sv -----
package lrl_pkg;

    // request codes
    localparam logic [1:0] REQ_CHECK   = 2'd0;
    localparam logic [1:0] REQ_FAIL    = 2'd1;
    localparam logic [1:0] REQ_SUCCESS = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_WINDOW_MS    = 2'd0;
    localparam logic [1:0] CFG_MAX_ATTEMPTS = 2'd1;
    localparam logic [1:0] CFG_LOCKOUT_MS   = 2'd2;

    localparam logic [31:0] WINDOW_MS_RST    = 32'd300000;
    localparam logic [15:0] MAX_ATTEMPTS_RST = 16'd5;
    localparam logic [31:0] LOCKOUT_MS_RST   = 32'd300000;

    localparam logic [15:0] ATTEMPTS_SAT = 16'hFFFF;
    localparam logic [31:0] OLDEST_INIT  = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] client_key;
        logic [31:0] now_ms;
    } req_t;

    typedef struct packed {
        logic        limited;
        logic        table_full;
        logic [15:0] attempt_count;
    } rsp_t;

    typedef struct packed {
        logic [63:0] key;
        logic [31:0] window_start;
        logic [15:0] attempts;
        logic [31:0] lockout_until;
    } slot_rec_t;

    typedef struct packed {
        logic load;     // latch request, restart scan
        logic scan;     // walk the slot table
        logic resolve;  // pick the slot, precompute time compares
        logic commit;   // write back slot, load result
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } ctrl_stat_t;

endpackage

// ----- design/lrl_ctrl.sv -----
module lrl_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  lrl_pkg::ctrl_stat_t stat,
    output lrl_pkg::ctrl_cmd_t  cmd
);
    import lrl_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_SCAN    = 4'b0010,
        ST_RESOLVE = 4'b0100,
        ST_COMMIT  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        req_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                cmd.resolve = 1'b1;
                state_next  = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                // hold until the previous result has left
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- design/lrl_datapath.sv -----
module lrl_datapath #(
    parameter int SLOTS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lrl_pkg::ctrl_cmd_t  cmd,
    output lrl_pkg::ctrl_stat_t stat,
    input  lrl_pkg::req_t       req_in,
    input  logic [31:0]         window_ms,
    input  logic [15:0]         max_attempts,
    input  logic [31:0]         lockout_ms,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output lrl_pkg::rsp_t       rsp_data
);
    import lrl_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SLOT_W:0]   PTR_END  = (SLOT_W + 1)'(SLOTS);
    localparam logic [SLOT_W-1:0] IDX_LAST = SLOT_W'(SLOTS - 1);

    slot_rec_t         mem [SLOTS];
    logic [SLOTS-1:0]  used_reg;

    req_t              req_reg;
    logic [SLOT_W:0]   rd_ptr_reg;
    slot_rec_t         rd_rec_reg;
    logic              eval_vld_reg;
    logic [SLOT_W-1:0] eval_idx_reg;

    // scan trackers
    logic              hit_reg;
    logic [SLOT_W-1:0] hit_idx_reg;
    slot_rec_t         hit_rec_reg;
    logic              free_reg;
    logic [SLOT_W-1:0] free_idx_reg;
    logic              vic_reg;
    logic [SLOT_W-1:0] vic_idx_reg;
    logic [31:0]       vic_ws_reg;

    // resolved slot
    slot_rec_t         cur_rec_reg;
    logic              found_reg;
    logic [SLOT_W-1:0] slot_idx_reg;
    logic              expired_reg;
    logic [31:0]       deadline_reg;
    logic              locked_reg;

    logic              rsp_valid_reg;
    rsp_t              rsp_data_reg;

    logic              is_record;
    logic              issue;
    logic              ent_used;
    logic              ent_locked;
    slot_rec_t         fresh_rec;
    slot_rec_t         sel_rec;
    logic              out_free;

    logic [15:0]       base_att;
    logic [15:0]       new_att;
    logic              fail_lim;
    slot_rec_t         wr_rec;
    logic              wr_en;
    rsp_t              rsp_next;

    assign is_record = (req_reg.req_type == REQ_FAIL) || (req_reg.req_type == REQ_SUCCESS);
    assign issue     = cmd.scan && (rd_ptr_reg < PTR_END);
    assign ent_used  = used_reg[eval_idx_reg];
    assign ent_locked = (rd_rec_reg.lockout_until != 32'd0)
                        && (req_reg.now_ms < rd_rec_reg.lockout_until);
    assign out_free  = !rsp_valid_reg || rsp_ready;

    assign stat.scan_done = eval_vld_reg && (eval_idx_reg == IDX_LAST);
    assign stat.out_free  = out_free;

    always_comb
    begin
        fresh_rec.key           = req_reg.client_key;
        fresh_rec.window_start  = req_reg.now_ms;
        fresh_rec.attempts      = 16'd0;
        fresh_rec.lockout_until = 32'd0;
        sel_rec = hit_reg ? hit_rec_reg : fresh_rec;
    end

    // scan: one record read per cycle, evaluated the cycle after
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg   <= '0;
            eval_vld_reg <= 1'b0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            vic_reg      <= 1'b0;
        end
        else if (cmd.load)
        begin
            rd_ptr_reg   <= '0;
            eval_vld_reg <= 1'b0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            vic_reg      <= 1'b0;
        end
        else
        begin
            eval_vld_reg <= issue;
            if (issue)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (eval_vld_reg)
            begin
                if (ent_used && !hit_reg && (rd_rec_reg.key == req_reg.client_key))
                begin
                    hit_reg <= 1'b1;
                end
                if (!ent_used && !free_reg)
                begin
                    free_reg <= 1'b1;
                end
                if (ent_used && !ent_locked
                    && (!vic_reg || (rd_rec_reg.window_start <= vic_ws_reg)))
                begin
                    vic_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg    <= req_in;
            vic_ws_reg <= OLDEST_INIT;
        end
        if (issue)
        begin
            eval_idx_reg <= rd_ptr_reg[SLOT_W-1:0];
        end
        if (eval_vld_reg)
        begin
            if (ent_used && !hit_reg && (rd_rec_reg.key == req_reg.client_key))
            begin
                hit_idx_reg <= eval_idx_reg;
                hit_rec_reg <= rd_rec_reg;
            end
            if (!ent_used && !free_reg)
            begin
                free_idx_reg <= eval_idx_reg;
            end
            if (ent_used && !ent_locked
                && (!vic_reg || (rd_rec_reg.window_start <= vic_ws_reg)))
            begin
                vic_idx_reg <= eval_idx_reg;
                vic_ws_reg  <= rd_rec_reg.window_start;
            end
        end
        if (cmd.resolve)
        begin
            cur_rec_reg  <= sel_rec;
            found_reg    <= is_record ? (hit_reg || free_reg || vic_reg) : hit_reg;
            slot_idx_reg <= hit_reg ? hit_idx_reg : (free_reg ? free_idx_reg : vic_idx_reg);
            expired_reg  <= (req_reg.now_ms - sel_rec.window_start) > window_ms;
            deadline_reg <= req_reg.now_ms + lockout_ms;
            locked_reg   <= (hit_rec_reg.lockout_until != 32'd0)
                            && (req_reg.now_ms < hit_rec_reg.lockout_until);
        end
    end

    // update of the chosen slot and the result
    always_comb
    begin
        base_att = expired_reg ? 16'd0 : cur_rec_reg.attempts;
        new_att  = (base_att == ATTEMPTS_SAT) ? base_att : base_att + 16'd1;
        fail_lim = new_att >= max_attempts;
        wr_rec   = cur_rec_reg;
        rsp_next = '0;
        wr_en    = 1'b0;
        if (is_record)
        begin
            if (!found_reg)
            begin
                rsp_next.limited    = 1'b1;
                rsp_next.table_full = 1'b1;
            end
            else if (req_reg.req_type == REQ_SUCCESS)
            begin
                wr_en                = 1'b1;
                wr_rec.attempts      = 16'd0;
                wr_rec.lockout_until = 32'd0;
                wr_rec.window_start  = req_reg.now_ms;
            end
            else
            begin
                wr_en                  = 1'b1;
                wr_rec.window_start    = expired_reg ? req_reg.now_ms : cur_rec_reg.window_start;
                wr_rec.attempts        = new_att;
                wr_rec.lockout_until   = fail_lim ? deadline_reg : cur_rec_reg.lockout_until;
                rsp_next.limited       = fail_lim;
                rsp_next.attempt_count = new_att;
            end
        end
        else if (found_reg)
        begin
            rsp_next.limited       = locked_reg;
            rsp_next.attempt_count = cur_rec_reg.attempts;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_rec_reg <= mem[rd_ptr_reg[SLOT_W-1:0]];
        end
        if (cmd.commit && wr_en)
        begin
            mem[slot_idx_reg] <= wr_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit && wr_en)
            begin
                used_reg[slot_idx_reg] <= 1'b1;
            end
            if (cmd.commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rsp_data_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

// ----- design/login_rate_limiter_table.sv -----
// Channel | Dir | Handshake              | Payload
// req     | in  | req_valid / req_ready  | req_data  : req_type, client_key, now_ms
// rsp     | out | rsp_valid / rsp_ready  | rsp_data  : limited, table_full, attempt_count
// cfg     | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data (window, max attempts, lockout)
//
// Flow: one request at a time. The slot scan reads the record memory one slot
//   per cycle; then a resolve step picks the slot, and a commit step writes it
//   back and loads the result.
// Reset: slot valid bits clear at once, no clearing pass; config takes defaults.
// Stalls: the result sits in an output register; a new request is taken while
//   it waits, but its write-back holds until the old result is taken.
module login_rate_limiter_table #(
    parameter int SLOTS = 8
) (
    input  logic           clk,
    input  logic           rst_n,

    // request transaction
    input  logic           req_valid,
    output logic           req_ready,
    input  lrl_pkg::req_t  req_data,

    // result transaction
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output lrl_pkg::rsp_t  rsp_data,

    // configuration write transaction
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [1:0]     cfg_index,
    input  logic [31:0]    cfg_data
);
    import lrl_pkg::*;

    logic [31:0] window_ms_reg;
    logic [15:0] max_attempts_reg;
    logic [31:0] lockout_ms_reg;

    ctrl_cmd_t   cmd;
    ctrl_stat_t  stat;

    // Config writes are always accepted and registered directly; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_ms_reg    <= WINDOW_MS_RST;
            max_attempts_reg <= MAX_ATTEMPTS_RST;
            lockout_ms_reg   <= LOCKOUT_MS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WINDOW_MS:    window_ms_reg    <= cfg_data;
                CFG_MAX_ATTEMPTS: max_attempts_reg <= cfg_data[15:0];
                CFG_LOCKOUT_MS:   lockout_ms_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Sequencer: idle -> scan -> resolve -> commit.
    lrl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Slot table, scan trackers, update arithmetic and output register.
    lrl_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .req_in       (req_data),
        .window_ms    (window_ms_reg),
        .max_attempts (max_attempts_reg),
        .lockout_ms   (lockout_ms_reg),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .rsp_data     (rsp_data)
    );

    // A full table always fails closed with no count.
    a_full_closed: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.table_full |-> rsp_data.limited
            && (rsp_data.attempt_count == 16'd0))
        else $error("table_full result without limited or with nonzero count");

    // Only one request in flight.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another is in flight");

    // Write-back never overruns a result still waiting.
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!rsp_valid || rsp_ready))
        else $error("commit while output register occupied");

    // End of scan is only seen during the scan.
    a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
        stat.scan_done |-> cmd.scan)
        else $error("scan done outside of scan");

endmodule
